// ----- sv/lpr_pkg.sv -----
package lpr_pkg;

    // port widths fixed by the interface
    localparam int PAGE_W      = 10;
    localparam int FRAME_IDX_W = 4;
    localparam int FAULT_W     = 16;
    localparam int STAMP_W     = 32;
    localparam int CFG_W       = 5;

    // defaults for the top level parameters
    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 10;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    // controller to datapath commands
    typedef struct packed {
        logic load;        // capture the input word
        logic start_scan;  // seed the oldest-stamp search
        logic scan_step;   // examine one more frame
        logic commit;      // update table, counters and output register
        logic evict;       // commit uses the search winner
    } lpr_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic hit;         // page resident
        logic full;        // no empty frame among those in use
        logic scan_done;   // search has covered all frames in use
        logic slot_free;   // output register can take a word
    } lpr_sts_t;

endpackage

// ----- sv/lpr_ctrl.sv -----
module lpr_ctrl
    import lpr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  lpr_sts_t sts,
    output lpr_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOOK  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_EVICT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (sts.hit || !sts.full)
                begin
                    if (sts.slot_free)
                    begin
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.start_scan = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                    state_next = ST_EVICT;
                else
                    cmd.scan_step = 1'b1;
            end
            ST_EVICT:
            begin
                if (sts.slot_free)
                begin
                    cmd.commit = 1'b1;
                    cmd.evict  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- sv/lpr_datapath.sv -----
module lpr_datapath
    import lpr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lpr_cmd_t               cmd,
    output lpr_sts_t               sts,
    input  logic [PAGE_W-1:0]      page_number,
    input  logic                   last_reference,
    input  logic                   cfg_write,
    input  logic [CFG_W-1:0]       frames_in_use,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   hit,
    output logic [FRAME_IDX_W-1:0] frame_index,
    output logic                   evicted_valid,
    output logic [PAGE_W-1:0]      evicted_page,
    output logic [FAULT_W-1:0]     fault_total,
    output logic                   stamp_saturated
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);

    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;
    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    // frame table
    logic [PAGE_BITS-1:0] page_mem_reg  [FRAMES];
    logic [STAMP_W-1:0]   stamp_mem_reg [FRAMES];

    logic [CFG_W-1:0]     cfg_frames_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic                 last_reg;
    logic [CNT_W-1:0]     filled_reg;
    logic [FAULT_W-1:0]   fault_reg;
    logic [STAMP_W-1:0]   ref_stamp_reg;

    // oldest-stamp search
    logic [CNT_W-1:0]     scan_idx_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [STAMP_W-1:0]   best_stamp_reg;

    // output register
    logic                   out_valid_reg;
    logic                   hit_reg;
    logic [FRAME_IDX_W-1:0] frame_index_reg;
    logic                   ev_valid_reg;
    logic [PAGE_W-1:0]      ev_page_reg;
    logic [FAULT_W-1:0]     fault_total_reg;
    logic                   stamp_sat_reg;

    logic [CNT_W-1:0]   used;
    logic [FRAMES-1:0]  match;
    logic               hit_any;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   commit_idx;
    logic               commit_hit;
    logic [FAULT_W-1:0] fault_next;
    logic [STAMP_W-1:0] stamp_next;
    logic [STAMP_W-1:0] scan_stamp;

    // zero counts as one, anything past the table as the full table
    always_comb
    begin
        if (cfg_frames_reg == '0)
            used = CNT_W'(1);
        else if (32'(cfg_frames_reg) > 32'(FRAMES))
            used = CNT_W'(FRAMES);
        else
            used = CNT_W'(cfg_frames_reg);
    end

    // parallel compare, lowest matching frame wins
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < FRAMES; i++)
            match[i] = (32'(filled_reg) > i) && (page_mem_reg[i] == page_reg);
        for (int i = FRAMES - 1; i >= 0; i--)
            if (match[i])
                hit_idx = IDX_W'(i);
    end

    assign hit_any    = |match;
    assign commit_hit = !cmd.evict && hit_any;
    assign commit_idx = cmd.evict ? best_idx_reg
                      : (hit_any ? hit_idx : filled_reg[IDX_W-1:0]);
    assign fault_next = (commit_hit || fault_reg == FAULT_MAX) ? fault_reg
                      : fault_reg + FAULT_W'(1);
    assign stamp_next = (ref_stamp_reg == STAMP_MAX) ? ref_stamp_reg
                      : ref_stamp_reg + STAMP_W'(1);
    assign scan_stamp = stamp_mem_reg[scan_idx_reg[IDX_W-1:0]];

    assign sts.hit       = hit_any;
    assign sts.full      = (filled_reg >= used);
    assign sts.scan_done = (scan_idx_reg >= used);
    assign sts.slot_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_frames_reg <= CFG_RESET;
            filled_reg     <= '0;
            fault_reg      <= '0;
            ref_stamp_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                cfg_frames_reg <= frames_in_use;
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    filled_reg    <= '0;
                    fault_reg     <= '0;
                    ref_stamp_reg <= '0;
                end
                else
                begin
                    if (!commit_hit && !cmd.evict)
                        filled_reg <= filled_reg + CNT_W'(1);
                    fault_reg     <= fault_next;
                    ref_stamp_reg <= stamp_next;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg <= PAGE_BITS'(page_number);
            last_reg <= last_reference;
        end
        if (cmd.start_scan)
        begin
            best_idx_reg   <= '0;
            best_stamp_reg <= stamp_mem_reg[0];
            scan_idx_reg   <= CNT_W'(1);
        end
        else if (cmd.scan_step)
        begin
            if (scan_stamp < best_stamp_reg)
            begin
                best_idx_reg   <= scan_idx_reg[IDX_W-1:0];
                best_stamp_reg <= scan_stamp;
            end
            scan_idx_reg <= scan_idx_reg + CNT_W'(1);
        end
        if (cmd.commit)
        begin
            if (!commit_hit)
                page_mem_reg[commit_idx] <= page_reg;
            stamp_mem_reg[commit_idx] <= ref_stamp_reg;
            hit_reg         <= commit_hit;
            frame_index_reg <= FRAME_IDX_W'(commit_idx);
            ev_valid_reg    <= cmd.evict;
            ev_page_reg     <= cmd.evict ? PAGE_W'(page_mem_reg[best_idx_reg]) : '0;
            fault_total_reg <= fault_next;
            stamp_sat_reg   <= (stamp_next == STAMP_MAX);
        end
    end

    assign out_valid       = out_valid_reg;
    assign hit             = hit_reg;
    assign frame_index     = frame_index_reg;
    assign evicted_valid   = ev_valid_reg;
    assign evicted_page    = ev_page_reg;
    assign fault_total     = fault_total_reg;
    assign stamp_saturated = stamp_sat_reg;

endmodule

// ----- sv/lru_page_replacement_unit.sv -----
// lru page replacement, fully associative frame table
// sequence: the accepted reference is looked up, and a hit or a fill of an empty frame
//   commits from the lookup state; an eviction first runs the one-frame-per-cycle
//   oldest-stamp scan over the used stamps (used = frames in use after clamping), then
//   commits; a commit waits for a free output slot. throughput: one item at a time
// reset: table empty, counts and stamp zero, frames_in_use back to 16
module lru_page_replacement_unit
    import lpr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // reference words
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PAGE_W-1:0]      page_number,
    input  logic                   last_reference,

    // result words
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   hit,
    output logic [FRAME_IDX_W-1:0] frame_index,
    output logic                   evicted_valid,
    output logic [PAGE_W-1:0]      evicted_page,
    output logic [FAULT_W-1:0]     fault_total,
    output logic                   stamp_saturated,

    // frames_in_use register write
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       frames_in_use
);

    lpr_cmd_t cmd;
    lpr_sts_t sts;

    // writes land only while the sequencer is idle, never under a lookup or scan
    assign cfg_ready = !in_stall;

    // sequencer: idle -> lookup -> (scan -> evict) -> idle
    lpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // frame table, compare lanes, stamp scan, counters and result register
    lpr_datapath #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .page_number     (page_number),
        .last_reference  (last_reference),
        .cfg_write       (cfg_valid && cfg_ready),
        .frames_in_use   (frames_in_use),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hit             (hit),
        .frame_index     (frame_index),
        .evicted_valid   (evicted_valid),
        .evicted_page    (evicted_page),
        .fault_total     (fault_total),
        .stamp_saturated (stamp_saturated)
    );

    // one reference in flight: an accepted word closes the input next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while a reference is in flight");

    // a result is only committed when the output register can take it
    a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> sts.slot_free)
        else $error("result committed over an untaken word");

    // search commands never overlap a commit
    a_scan_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start_scan || cmd.scan_step) |-> !cmd.commit)
        else $error("scan and commit in the same cycle");

    // an eviction is always a fault
    a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && evicted_valid) |-> (!hit && fault_total != '0))
        else $error("eviction reported on a hit or with no fault counted");

endmodule
